/* src/bda_pkg.sv */
// Shared types and constants for the button debounce / auto-repeat block.
// No dependencies.
package bda_pkg;

	localparam int NUM_BUTTONS = 8;
	localparam int TIME_WIDTH  = 32;
	localparam int BTN_W       = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;

	localparam int IDX_W   = 3;
	localparam int NOW_W   = 32;
	localparam int DELAY_W = 16;
	localparam int CFG_IDX_W = 2;

	localparam logic [DELAY_W-1:0] DEBOUNCE_RST = 16'd30;
	localparam logic [DELAY_W-1:0] INITIAL_RST  = 16'd500;
	localparam logic [DELAY_W-1:0] REPEAT_RST   = 16'd100;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_DEBOUNCE = 2'd0,
		REG_INITIAL  = 2'd1,
		REG_REPEAT   = 2'd2
	} cfg_reg_t;

	typedef struct packed {
		logic [DELAY_W-1:0] debounce_ms;
		logic [DELAY_W-1:0] initial_delay_ms;
		logic [DELAY_W-1:0] repeat_delay_ms;
	} cfg_t;

	typedef struct packed {
		logic [IDX_W-1:0] button_index;
		logic             raw_pressed;
		logic [NOW_W-1:0] now_ms;
	} poll_t;

endpackage

/* src/bda_poll_if.sv */
// Poll channel: one beat is one sample of one button.
// Depends on bda_pkg.
interface bda_poll_if;
	import bda_pkg::*;
	logic             valid;
	logic             ready;
	logic [IDX_W-1:0] button_index;
	logic             raw_pressed;
	logic [NOW_W-1:0] now_ms;

	modport source (output valid, button_index, raw_pressed, now_ms, input ready);
	modport sink   (input valid, button_index, raw_pressed, now_ms, output ready);
endinterface

/* src/bda_result_if.sv */
// Result channel: one beat carries the fire flag of one poll.
// No dependencies.
interface bda_result_if;
	logic valid;
	logic ready;
	logic fire;

	modport source (output valid, fire, input ready);
	modport sink   (input valid, fire, output ready);
endinterface

/* src/bda_cfg_if.sv */
// Configuration write channel: register index and write data per beat.
// Depends on bda_pkg.
interface bda_cfg_if;
	import bda_pkg::*;
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [DELAY_W-1:0]   data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

/* src/button_debounce_autorepeat_top.sv */
// Top level of the button debounce / auto-repeat block.
// Depends on bda_pkg, the channel interfaces, bda_cfg_regs and bda_engine.
//
// Accepts one poll per clock cycle while the result side does not stall, and
// returns one fire beat per poll: the poll is held in the input register,
// then a read-modify-write of the polled button's timers and levels loads
// the result register. A held result does not block the next poll, which
// waits in the input register.
module button_debounce_autorepeat_top
	import bda_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	bda_poll_if.sink      poll,
	bda_result_if.source  result,
	bda_cfg_if.sink       cfg
);

	cfg_t  regs;
	poll_t poll_s1;
	logic  valid_s1;
	logic  res_valid_q;
	logic  fire_q;
	logic  advance;
	logic  fire_c;

	assign advance    = valid_s1 && (!res_valid_q || result.ready);
	assign poll.ready = !valid_s1 || advance;

	bda_cfg_regs u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.regs   (regs)
	);

	bda_engine u_engine (
		.clk     (clk),
		.arst_n  (arst_n),
		.regs    (regs),
		.advance (advance),
		.item    (poll_s1),
		.fire    (fire_c)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (poll.ready) begin
			valid_s1 <= poll.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (poll.valid && poll.ready) begin
			poll_s1.button_index <= poll.button_index;
			poll_s1.raw_pressed  <= poll.raw_pressed;
			poll_s1.now_ms       <= poll.now_ms;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= 1'b1;
		end else if (result.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance)
			fire_q <= fire_c;
	end

	assign result.valid = res_valid_q;
	assign result.fire  = fire_q;

endmodule

/* src/bda_cfg_regs.sv */
// Configuration registers: debounce, initial delay and repeat interval.
// Depends on bda_pkg and bda_cfg_if.
module bda_cfg_regs
	import bda_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	bda_cfg_if.sink    cfg,
	output cfg_t       regs
);

	cfg_t regs_q;

	assign cfg.ready = 1'b1;
	assign regs      = regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.debounce_ms      <= DEBOUNCE_RST;
			regs_q.initial_delay_ms <= INITIAL_RST;
			regs_q.repeat_delay_ms  <= REPEAT_RST;
		end else if (cfg.valid) begin
			case (cfg_reg_t'(cfg.index))
				REG_DEBOUNCE: regs_q.debounce_ms      <= cfg.data;
				REG_INITIAL:  regs_q.initial_delay_ms <= cfg.data;
				REG_REPEAT:   regs_q.repeat_delay_ms  <= cfg.data;
				default: ;
			endcase
		end
	end

endmodule

/* src/bda_engine.sv */
// Per-button state and the read-modify-write of one poll.
// Depends on bda_pkg.
module bda_engine
	import bda_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  cfg_t  regs,
	input  logic  advance,
	input  poll_t item,
	output logic  fire
);

	logic [NUM_BUTTONS-1:0]  last_raw_q;
	logic [NUM_BUTTONS-1:0]  stable_q;
	logic [NUM_BUTTONS-1:0]  first_done_q;
	logic [TIME_WIDTH-1:0]   change_time_q [NUM_BUTTONS];
	logic [TIME_WIDTH-1:0]   repeat_time_q [NUM_BUTTONS];
	logic [BTN_W-1:0]        owner_idx_q;
	logic                    owner_valid_q;

	logic [BTN_W-1:0]      b;
	logic                  in_range;
	logic [TIME_WIDTH-1:0] now;
	logic                  raw;
	logic [TIME_WIDTH-1:0] ct_n;
	logic [TIME_WIDTH-1:0] since_change;
	logic [TIME_WIDTH-1:0] since_repeat;
	logic [TIME_WIDTH-1:0] limit;
	logic                  accept;
	logic                  press;
	logic                  release_ev;
	logic                  owner_here;
	logic                  st_n;
	logic                  rep_fire;

	always_comb begin
		b          = item.button_index[BTN_W-1:0];
		in_range   = (32'(item.button_index) < 32'(NUM_BUTTONS));
		now        = TIME_WIDTH'(item.now_ms);
		raw        = item.raw_pressed;
		ct_n       = (raw != last_raw_q[b]) ? now : change_time_q[b];
		since_change = now - ct_n;
		accept     = (since_change > TIME_WIDTH'(regs.debounce_ms)) && (stable_q[b] != raw);
		press      = accept && raw;
		release_ev = accept && !raw;
		owner_here = owner_valid_q && (owner_idx_q == b);
		st_n       = accept ? raw : stable_q[b];
		limit      = first_done_q[b] ? TIME_WIDTH'(regs.repeat_delay_ms)
		                             : TIME_WIDTH'(regs.initial_delay_ms);
		since_repeat = now - repeat_time_q[b];
		rep_fire   = !press && st_n && owner_here && (since_repeat >= limit);
		fire       = in_range && (press || rep_fire);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_raw_q    <= '0;
			stable_q      <= '0;
			first_done_q  <= '0;
			owner_idx_q   <= '0;
			owner_valid_q <= 1'b0;
			for (int i = 0; i < NUM_BUTTONS; i++) begin
				change_time_q[i] <= '0;
				repeat_time_q[i] <= '0;
			end
		end else if (advance && in_range) begin
			last_raw_q[b]    <= raw;
			change_time_q[b] <= ct_n;
			stable_q[b]      <= st_n;
			if (press) begin
				repeat_time_q[b] <= now;
				first_done_q[b]  <= 1'b0;
				owner_idx_q      <= b;
				owner_valid_q    <= 1'b1;
			end else if (rep_fire) begin
				repeat_time_q[b] <= now;
				first_done_q[b]  <= 1'b1;
			end
			if (release_ev && owner_here)
				owner_valid_q <= 1'b0;
		end
	end

	// a valid owner always holds a debounced press
	a_owner_pressed: assert property (@(posedge clk) disable iff (!arst_n)
		owner_valid_q |-> stable_q[owner_idx_q])
		else $error("owner is not in pressed state");

	a_press_owns: assert property (@(posedge clk) disable iff (!arst_n)
		advance && in_range && press |=> owner_valid_q && (owner_idx_q == $past(b)))
		else $error("press did not take ownership");

	a_repeat_stamp: assert property (@(posedge clk) disable iff (!arst_n)
		advance && in_range && rep_fire |=>
		first_done_q[$past(b)] && (repeat_time_q[$past(b)] == $past(now)))
		else $error("repeat fire did not restamp");

endmodule

/* dv/button_debounce_autorepeat_top_tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for button_debounce_autorepeat_top: directed and random polls
// against a typematic predictor kept in a scoreboard class.
// Depends on bda_pkg, the poll/result/cfg interfaces and the top level.
module button_debounce_autorepeat_top_tb;
	import bda_pkg::*;

	localparam int CYCLE_LIMIT = 500000;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

	class typematic_scoreboard;
		cfg_t                  regs;
		bit                    last_raw   [NUM_BUTTONS];
		logic [TIME_WIDTH-1:0] change_time[NUM_BUTTONS];
		bit                    debounced  [NUM_BUTTONS];
		logic [TIME_WIDTH-1:0] repeat_time[NUM_BUTTONS];
		bit                    repeated   [NUM_BUTTONS];
		logic [BTN_W-1:0]      owner;
		bit                    owner_valid;
		bit                    expected_fire[$];
		int                    errors;

		function new();
			regs.debounce_ms      = DEBOUNCE_RST;
			regs.initial_delay_ms = INITIAL_RST;
			regs.repeat_delay_ms  = REPEAT_RST;
			for (int i = 0; i < NUM_BUTTONS; i++) begin
				last_raw[i]    = 0;
				change_time[i] = '0;
				debounced[i]   = 0;
				repeat_time[i] = '0;
				repeated[i]    = 0;
			end
			owner       = '0;
			owner_valid = 0;
			errors      = 0;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [DELAY_W-1:0] data);
			case (idx)
				REG_DEBOUNCE: regs.debounce_ms      = data;
				REG_INITIAL:  regs.initial_delay_ms = data;
				REG_REPEAT:   regs.repeat_delay_ms  = data;
				default: ;
			endcase
		endfunction

		function void note_poll(poll_t p);
			logic [BTN_W-1:0]      b;
			logic [TIME_WIDTH-1:0] now;
			logic [TIME_WIDTH-1:0] age;
			logic [TIME_WIDTH-1:0] limit;
			bit                    raw;
			bit                    fire;
			bit                    pressed;
			b       = p.button_index[BTN_W-1:0];
			raw     = p.raw_pressed;
			now     = p.now_ms[TIME_WIDTH-1:0];
			fire    = 0;
			pressed = 0;
			if (p.button_index < NUM_BUTTONS) begin
				if (raw != last_raw[b]) begin
					change_time[b] = now;
					last_raw[b]    = raw;
				end
				age = now - change_time[b];
				if (age > regs.debounce_ms && debounced[b] != raw) begin
					debounced[b] = raw;
					if (raw) begin
						repeat_time[b] = now;
						repeated[b]    = 0;
						owner          = b;
						owner_valid    = 1;
						fire           = 1;
						pressed        = 1;
					end else if (owner_valid && owner == b) begin
						owner_valid = 0;
					end
				end
				if (!pressed && debounced[b] && owner_valid && owner == b) begin
					limit = repeated[b] ? TIME_WIDTH'(regs.repeat_delay_ms)
					                    : TIME_WIDTH'(regs.initial_delay_ms);
					age   = now - repeat_time[b];
					if (age >= limit) begin
						repeat_time[b] = now;
						repeated[b]    = 1;
						fire           = 1;
					end
				end
			end
			expected_fire.push_back(fire);
		endfunction

		function void check_fire(bit fire);
			bit exp_fire;
			if (expected_fire.size() == 0) begin
				$display("%0t: fire beat with nothing pending, expected none, got %0b",
					$time, fire);
				errors++;
			end else begin
				exp_fire = expected_fire.pop_front();
				if (exp_fire !== fire) begin
					$display("%0t: fire mismatch, expected %0b, got %0b", $time, exp_fire, fire);
					errors++;
				end
			end
		endfunction

		function int pending();
			return expected_fire.size();
		endfunction

		function void close();
			while (expected_fire.size() > 0) begin
				$display("%0t: missing fire beat, expected %0b, got none",
					$time, expected_fire.pop_front());
				errors++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;

	bda_poll_if   poll_if();
	bda_result_if res_if();
	bda_cfg_if    cfg_if();

	button_debounce_autorepeat_top DUT (
		.clk(clk),
		.arst_n(arst_n),
		.poll(poll_if),
		.result(res_if),
		.cfg(cfg_if)
	);

	typematic_scoreboard sb = new();

	logic [NOW_W-1:0] stim_now;
	bit               held[NUM_BUTTONS];
	int               focus;
	int               poll_mode;

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// mode 0: no idling, 1: light, 2: heavy
	function automatic int pick_gap(int mode);
		int r;
		r = $urandom_range(0, 99);
		if (mode == 0)
			return 0;
		if (mode == 1) begin
			if (r < 70) return 0;
			if (r < 95) return $urandom_range(1, 3);
			return $urandom_range(8, 30);
		end
		if (r < 40) return 0;
		if (r < 85) return $urandom_range(1, 4);
		return $urandom_range(10, 40);
	endfunction

	task automatic send_poll(input logic [IDX_W-1:0] b, input bit raw,
			input logic [NOW_W-1:0] now);
		int    gap;
		poll_t p;
		gap = pick_gap(poll_mode);
		p.button_index = b;
		p.raw_pressed  = raw;
		p.now_ms       = now;
		@(negedge clk);
		if (gap > 0) begin
			poll_if.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		poll_if.valid        = 1'b1;
		poll_if.button_index = b;
		poll_if.raw_pressed  = raw;
		poll_if.now_ms       = now;
		do @(posedge clk); while (!poll_if.ready);
		sb.note_poll(p);
	endtask

	task automatic wait_drained();
		@(negedge clk);
		poll_if.valid = 1'b0;
		while (sb.pending() > 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [DELAY_W-1:0] data);
		@(negedge clk);
		cfg_if.valid = 1'b1;
		cfg_if.index = idx;
		cfg_if.data  = data;
		do @(posedge clk); while (!cfg_if.ready);
		sb.write_reg(idx, data);
		@(negedge clk);
		cfg_if.valid = 1'b0;
	endtask

	task automatic set_config(input logic [DELAY_W-1:0] deb, input logic [DELAY_W-1:0] ini,
			input logic [DELAY_W-1:0] rep);
		wait_drained();
		cfg_write(REG_DEBOUNCE, deb);
		cfg_write(REG_INITIAL, ini);
		cfg_write(REG_REPEAT, rep);
	endtask

	// Mostly one focus button held or released in runs, other buttons in the
	// background, occasional bounces and time jumps.
	task automatic run_random(input int n, input int step_max);
		logic [IDX_W-1:0] b;
		bit               raw;
		for (int k = 0; k < n; k++) begin
			if (k % 40 == 0)
				poll_mode = $urandom_range(0, 2);
			if ($urandom_range(0, 99) == 0)
				stim_now = $urandom();
			else
				stim_now = stim_now + $urandom_range(0, step_max);
			if ($urandom_range(0, 29) == 0)
				focus = $urandom_range(0, NUM_BUTTONS - 1);
			if ($urandom_range(0, 99) < 65)
				b = IDX_W'(focus);
			else
				b = IDX_W'($urandom_range(0, NUM_BUTTONS - 1));
			if ($urandom_range(0, 99) < ((b == focus) ? 4 : 12))
				held[b] = !held[b];
			raw = held[b];
			if ($urandom_range(0, 99) < 6)
				raw = !raw;
			send_poll(b, raw, stim_now);
		end
	endtask

	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("CHECK FAILED");
		$finish;
	end

	initial begin
		int hold;
		int mode;
		int mode_left;
		hold         = 0;
		mode         = 0;
		mode_left    = 0;
		res_if.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (mode_left == 0) begin
				mode      = $urandom_range(0, 2);
				mode_left = $urandom_range(20, 80);
			end
			mode_left--;
			if (hold > 0) begin
				res_if.ready = 1'b0;
				hold--;
			end else begin
				res_if.ready = 1'b1;
				hold = pick_gap(mode);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && res_if.valid && res_if.ready)
			sb.check_fire(res_if.fire);
	end

	initial begin
		logic [DELAY_W-1:0] deb;
		logic [DELAY_W-1:0] ini;
		logic [DELAY_W-1:0] rep;
		arst_n               = 1'b0;
		poll_if.valid        = 1'b0;
		poll_if.button_index = '0;
		poll_if.raw_pressed  = 1'b0;
		poll_if.now_ms       = '0;
		cfg_if.valid         = 1'b0;
		cfg_if.index         = '0;
		cfg_if.data          = '0;
		stim_now             = '0;
		focus                = 0;
		poll_mode            = 0;
		for (int i = 0; i < NUM_BUTTONS; i++)
			held[i] = 0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset delays: debounce edge, first repeat, later repeats, owner handoff
		send_poll(3'd0, 1'b1, 32'd0);
		send_poll(3'd0, 1'b1, 32'd30);
		send_poll(3'd0, 1'b1, 32'd31);
		send_poll(3'd0, 1'b1, 32'd530);
		send_poll(3'd0, 1'b1, 32'd531);
		send_poll(3'd0, 1'b1, 32'd630);
		send_poll(3'd0, 1'b1, 32'd631);
		send_poll(3'd1, 1'b1, 32'd640);
		send_poll(3'd1, 1'b1, 32'd700);
		send_poll(3'd0, 1'b1, 32'd800);
		send_poll(3'd0, 1'b0, 32'd810);
		send_poll(3'd0, 1'b0, 32'd900);
		send_poll(3'd1, 1'b1, 32'd1200);
		send_poll(3'd1, 1'b0, 32'd1210);
		send_poll(3'd1, 1'b0, 32'd1300);
		// press debounced across the timestamp wrap
		send_poll(3'd7, 1'b1, 32'hFFFF_FFF0);
		send_poll(3'd7, 1'b1, 32'h0000_0010);
		send_poll(3'd7, 1'b0, 32'h0000_0020);
		send_poll(3'd7, 1'b1, 32'hFFFF_FFFF);
		send_poll(3'd3, 1'b0, 32'hFFFF_FFFF);
		send_poll(3'd3, 1'b1, 32'h0000_0000);
		stim_now = 32'd2000;
		run_random(110, 40);

		// zero delays: accept after 1 ms, repeat on every poll of the owner
		set_config(16'd0, 16'd0, 16'd0);
		run_random(110, 3);

		set_config(16'hFFFF, 16'hFFFF, 16'hFFFF);
		cfg_write(REG_UNUSED, DELAY_W'($urandom()));
		run_random(100, 25000);

		for (int round = 0; round < 3; round++) begin
			deb = DELAY_W'($urandom_range(0, 40));
			ini = DELAY_W'($urandom_range(0, 300));
			rep = DELAY_W'($urandom_range(0, 60));
			set_config(deb, ini, rep);
			if (round == 1)
				stim_now = 32'hFFFF_F000;
			run_random(110, deb / 2 + ini / 10 + 4);
		end

		wait_drained();
		sb.close();
		if (sb.errors == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

/* sim.f */
src/bda_pkg.sv
src/bda_poll_if.sv
src/bda_result_if.sv
src/bda_cfg_if.sv
src/bda_cfg_regs.sv
src/bda_engine.sv
src/button_debounce_autorepeat_top.sv
dv/button_debounce_autorepeat_top_tb.sv
